>>> design/smtc_pkg.sv
// ----------------------------------------------------------------------------
// smtc_pkg
// Shared constants, types and helpers for the scaled model-time clock.
// ----------------------------------------------------------------------------
package smtc_pkg;

    // Timebase and day counter size
    localparam int TICKS_PER_REAL_SECOND = 1000000;
    localparam int DAY_BITS              = 16;

    // Field widths
    localparam int RATIO_W    = 16;
    localparam int DAY_W      = 16;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int SECOND_W   = 6;
    localparam int PERIOD_W   = 36;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Product TICKS * ratio_y; never narrower than the period
    localparam int PROD_RAW_W = $clog2(TICKS_PER_REAL_SECOND + 1) + RATIO_W;
    localparam int PROD_W     = (PROD_RAW_W > PERIOD_W) ? PROD_RAW_W : PERIOD_W;
    localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_Y = CFG_IDX_W'(1);

    // Item actions
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    // Result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // Last legal value of each time field
    localparam logic [SECOND_W-1:0] LAST_SECOND = SECOND_W'(59);
    localparam logic [MINUTE_W-1:0] LAST_MINUTE = MINUTE_W'(59);
    localparam logic [HOUR_W-1:0]   LAST_HOUR   = HOUR_W'(23);

    // Controller -> datapath commands
    typedef struct packed {
        logic item_accept;
        logic ratio_x_wr;
        logic ratio_y_wr;
        logic div_start;
        logic div_step;
        logic period_load;
    } ctrl_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic div_done;
    } dp_status_t;

    function automatic logic [DAY_BITS-1:0] day_from_field(input logic [DAY_W-1:0] f);
        logic [31:0] wide;
        wide = 32'(f);
        return wide[DAY_BITS-1:0];
    endfunction

    function automatic logic [DAY_W-1:0] day_to_field(input logic [DAY_BITS-1:0] d);
        logic [31:0] wide;
        wide = 32'(d);
        return wide[DAY_W-1:0];
    endfunction

endpackage

>>> design/smtc_cfg_if.sv
// ----------------------------------------------------------------------------
// smtc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface smtc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [smtc_pkg::CFG_IDX_W-1:0]   index;
    logic [smtc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/smtc_cmd_if.sv
// ----------------------------------------------------------------------------
// smtc_cmd_if
// Request channel: tick or set-time request.
// ----------------------------------------------------------------------------
interface smtc_cmd_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [smtc_pkg::DAY_W-1:0]      set_day;
    logic [smtc_pkg::HOUR_W-1:0]     set_hour;
    logic [smtc_pkg::MINUTE_W-1:0]   set_minute;
    logic [smtc_pkg::SECOND_W-1:0]   set_second;

    modport source (output valid, action, set_day, set_hour, set_minute, set_second,
                    input ready);
    modport sink   (input valid, action, set_day, set_hour, set_minute, set_second,
                    output ready);
endinterface

>>> design/smtc_rsp_if.sv
// ----------------------------------------------------------------------------
// smtc_rsp_if
// Result channel: status, run flag, minute event and current model time.
// ----------------------------------------------------------------------------
interface smtc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            status;
    logic                            running;
    logic                            minute_event;
    logic [smtc_pkg::DAY_W-1:0]      day;
    logic [smtc_pkg::HOUR_W-1:0]     hour;
    logic [smtc_pkg::MINUTE_W-1:0]   minute;
    logic [smtc_pkg::SECOND_W-1:0]   second;

    modport source (output valid, status, running, minute_event, day, hour, minute,
                    second, input ready);
    modport sink   (input valid, status, running, minute_event, day, hour, minute,
                    second, output ready);
endinterface

>>> design/scaled_model_time_clock_core.sv
// ----------------------------------------------------------------------------
// scaled_model_time_clock_core
// A request's result is registered and valid in the cycle after accept.
// One request per cycle while idle; the result register frees as it is taken.
// A ratio write starts a period recompute through LOAD and DIVIDE: a
//   bit-serial divide of TICKS_PER_REAL_SECOND * ratio_y by ratio_x, one bit
//   per cycle, during which no request or further write is taken.
// Reset: ratios, period, tick counter and time clear to zero; clock stopped.
// ----------------------------------------------------------------------------
module scaled_model_time_clock_core
(
    input  logic       clk,
    input  logic       rst_n,
    smtc_cfg_if.sink   cfg,
    smtc_cmd_if.sink   cmd,
    smtc_rsp_if.source rsp
);

    // Controller <-> datapath
    smtc_pkg::ctrl_cmd_t  ctrl_cmd;
    smtc_pkg::dp_status_t dp_stat;

    // Controller: owns valid/ready on all three channels. Requests flow
    // while idle; a write to either ratio runs LOAD then DIVIDE.
    smtc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cfg_index (cfg.index),
        .cmd       (ctrl_cmd),
        .stat      (dp_stat)
    );

    // Datapath: tick is a 36-bit increment and compare against the stored
    // period, then the second/minute/hour/day carry chain. The time
    // counters change only on an accepted request, so they feed the result
    // directly; flags are registered alongside.
    smtc_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctrl_cmd),
        .stat         (dp_stat),
        .cfg_data     (cfg.data),
        .action       (cmd.action),
        .set_day      (cmd.set_day),
        .set_hour     (cmd.set_hour),
        .set_minute   (cmd.set_minute),
        .set_second   (cmd.set_second),
        .status       (rsp.status),
        .running      (rsp.running),
        .minute_event (rsp.minute_event),
        .day          (rsp.day),
        .hour         (rsp.hour),
        .minute       (rsp.minute),
        .second       (rsp.second)
    );

endmodule

>>> design/smtc_div.sv
// ----------------------------------------------------------------------------
// smtc_div
// Restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module smtc_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          step,
    input  logic [smtc_pkg::PROD_W-1:0]   dividend,
    input  logic [smtc_pkg::RATIO_W-1:0]  divisor,
    output logic [smtc_pkg::PROD_W-1:0]   quotient,
    output logic                          done
);

    logic [smtc_pkg::PROD_W-1:0]    dvd_reg, dvd_next;
    logic [smtc_pkg::RATIO_W-1:0]   rem_reg, rem_next;
    logic [smtc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [smtc_pkg::RATIO_W:0]     trial;
    logic [smtc_pkg::RATIO_W:0]     diff;
    logic                           fits;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[smtc_pkg::PROD_W-1]};
        fits  = trial >= {1'b0, divisor};
        diff  = trial - {1'b0, divisor};
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            cnt_next = smtc_pkg::DIV_CNT_W'(smtc_pkg::PROD_W);
        end
        else if (step && (cnt_reg != '0))
        begin
            dvd_next = {dvd_reg[smtc_pkg::PROD_W-2:0], fits};
            rem_next = fits ? diff[smtc_pkg::RATIO_W-1:0] : trial[smtc_pkg::RATIO_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign quotient = dvd_reg;
    assign done     = (cnt_reg == '0);

endmodule

>>> design/smtc_datapath.sv
// ----------------------------------------------------------------------------
// smtc_datapath
// Ratio registers, period computation, tick counter and time counters.
// ----------------------------------------------------------------------------
module smtc_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  smtc_pkg::ctrl_cmd_t             cmd,
    output smtc_pkg::dp_status_t            stat,
    input  logic [smtc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            action,
    input  logic [smtc_pkg::DAY_W-1:0]      set_day,
    input  logic [smtc_pkg::HOUR_W-1:0]     set_hour,
    input  logic [smtc_pkg::MINUTE_W-1:0]   set_minute,
    input  logic [smtc_pkg::SECOND_W-1:0]   set_second,
    output logic                            status,
    output logic                            running,
    output logic                            minute_event,
    output logic [smtc_pkg::DAY_W-1:0]      day,
    output logic [smtc_pkg::HOUR_W-1:0]     hour,
    output logic [smtc_pkg::MINUTE_W-1:0]   minute,
    output logic [smtc_pkg::SECOND_W-1:0]   second
);

    logic [smtc_pkg::RATIO_W-1:0]  ratio_x_reg, ratio_x_next;
    logic [smtc_pkg::RATIO_W-1:0]  ratio_y_reg, ratio_y_next;
    logic [smtc_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic [smtc_pkg::PERIOD_W-1:0] tick_count_reg, tick_count_next;
    logic [smtc_pkg::DAY_BITS-1:0] day_reg, day_next;
    logic [smtc_pkg::HOUR_W-1:0]   hour_reg, hour_next;
    logic [smtc_pkg::MINUTE_W-1:0] minute_reg, minute_next;
    logic [smtc_pkg::SECOND_W-1:0] second_reg, second_next;
    logic                          status_reg, status_next;
    logic                          running_reg, running_next;
    logic                          event_reg, event_next;

    logic [smtc_pkg::PROD_W-1:0]   product;
    logic [smtc_pkg::PROD_W-1:0]   quotient;
    logic                          div_done;
    logic                          runs;
    logic                          set_ok;
    logic [smtc_pkg::PERIOD_W-1:0] tick_inc;
    logic                          sec_due;

    // TICKS * ratio_y, constant multiplier, registered inside the divider
    assign product = smtc_pkg::PROD_W'(smtc_pkg::TICKS_PER_REAL_SECOND)
                   * smtc_pkg::PROD_W'(ratio_y_reg);

    smtc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (product),
        .divisor  (ratio_x_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign stat.div_done = div_done;

    always_comb
    begin
        runs     = (ratio_x_reg != '0) && (ratio_y_reg != '0);
        set_ok   = (set_hour <= smtc_pkg::LAST_HOUR) && (set_minute <= smtc_pkg::LAST_MINUTE)
                && (set_second <= smtc_pkg::LAST_SECOND);
        tick_inc = tick_count_reg + 1'b1;
        sec_due  = tick_inc >= period_reg;

        ratio_x_next    = ratio_x_reg;
        ratio_y_next    = ratio_y_reg;
        period_next     = period_reg;
        tick_count_next = tick_count_reg;
        day_next        = day_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        second_next     = second_reg;
        status_next     = status_reg;
        running_next    = running_reg;
        event_next      = event_reg;

        if (cmd.ratio_x_wr)
        begin
            ratio_x_next    = cfg_data[smtc_pkg::RATIO_W-1:0];
            tick_count_next = '0;
        end
        if (cmd.ratio_y_wr)
        begin
            ratio_y_next    = cfg_data[smtc_pkg::RATIO_W-1:0];
            tick_count_next = '0;
        end

        if (cmd.period_load)
        begin
            tick_count_next = '0;
            if (!runs)
                period_next = '0;
            else if (quotient > smtc_pkg::PROD_W'(smtc_pkg::PERIOD_MAX))
                period_next = smtc_pkg::PERIOD_MAX;
            else
                period_next = quotient[smtc_pkg::PERIOD_W-1:0];
        end

        if (cmd.item_accept)
        begin
            status_next  = smtc_pkg::STATUS_OK;
            running_next = runs;
            event_next   = 1'b0;
            if (action == smtc_pkg::ACT_SET)
            begin
                if (set_ok)
                begin
                    day_next    = smtc_pkg::day_from_field(set_day);
                    hour_next   = set_hour;
                    minute_next = set_minute;
                    second_next = set_second;
                end
                else
                begin
                    status_next = smtc_pkg::STATUS_RANGE;
                end
            end
            else if (runs)
            begin
                if (sec_due)
                begin
                    tick_count_next = '0;
                    if (second_reg >= smtc_pkg::LAST_SECOND)
                    begin
                        second_next = '0;
                        event_next  = 1'b1;
                        if (minute_reg >= smtc_pkg::LAST_MINUTE)
                        begin
                            minute_next = '0;
                            if (hour_reg >= smtc_pkg::LAST_HOUR)
                            begin
                                hour_next = '0;
                                day_next  = day_reg + 1'b1;
                            end
                            else
                            begin
                                hour_next = hour_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            minute_next = minute_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        second_next = second_reg + 1'b1;
                    end
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_x_reg    <= '0;
            ratio_y_reg    <= '0;
            period_reg     <= '0;
            tick_count_reg <= '0;
            day_reg        <= '0;
            hour_reg       <= '0;
            minute_reg     <= '0;
            second_reg     <= '0;
        end
        else
        begin
            ratio_x_reg    <= ratio_x_next;
            ratio_y_reg    <= ratio_y_next;
            period_reg     <= period_next;
            tick_count_reg <= tick_count_next;
            day_reg        <= day_next;
            hour_reg       <= hour_next;
            minute_reg     <= minute_next;
            second_reg     <= second_next;
        end
    end

    // Result flags; qualified by the controller's valid
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        running_reg <= running_next;
        event_reg   <= event_next;
    end

    assign status       = status_reg;
    assign running      = running_reg;
    assign minute_event = event_reg;
    assign day          = smtc_pkg::day_to_field(day_reg);
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;

endmodule

>>> design/smtc_ctrl.sv
// ----------------------------------------------------------------------------
// smtc_ctrl
// Handshake and sequencing: request/result flow and period recompute.
// ----------------------------------------------------------------------------
module smtc_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    output logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [smtc_pkg::CFG_IDX_W-1:0] cfg_index,
    output smtc_pkg::ctrl_cmd_t            cmd,
    input  smtc_pkg::dp_status_t           stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   cfg_acc;

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
        cfg_ready = (state_reg == ST_IDLE);
        cfg_acc   = cfg_valid && cfg_ready;

        cmd.item_accept = in_valid && in_ready;
        cmd.ratio_x_wr  = cfg_acc && (cfg_index == smtc_pkg::CFG_RATIO_X);
        cmd.ratio_y_wr  = cfg_acc && (cfg_index == smtc_pkg::CFG_RATIO_Y);
        cmd.div_start   = (state_reg == ST_LOAD);
        cmd.div_step    = (state_reg == ST_DIVIDE) && !stat.div_done;
        cmd.period_load = (state_reg == ST_DIVIDE) && stat.div_done;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.ratio_x_wr || cmd.ratio_y_wr)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (stat.div_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.item_accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
